// ===== rtl/frt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, status codes and types for the session slot table.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int SESSIONS      = 3;
	localparam int PAYLOAD_BYTES = 160;
	localparam int SLOT_W        = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	localparam logic [4:0] PART_MARK = 5'b11111;
	localparam logic [7:0] START_AGE = 8'd30;
	localparam logic [7:0] AGE_MAX   = 8'hFF;
	localparam logic [1:0] NO_SLOT   = 2'd3;
	localparam logic [10:0] LEN_MAX  = 11'h7FF;

	typedef enum logic [2:0] {
		ST_STARTED   = 3'd0,
		ST_APPENDED  = 3'd1,
		ST_LOST      = 3'd2,
		ST_FRAME_ERR = 3'd3,
		ST_DELIVERED = 3'd4
	} frag_status_t;

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  age;
		logic [7:0]  parts;
	} slot_t;

	typedef slot_t [SESSIONS-1:0] slot_vec_t;

	typedef struct packed {
		frag_status_t status;
		logic [10:0]  deliver_length;
		logic [1:0]   slot_used;
		logic [3:0]   full_parts;
	} result_t;

endpackage : frt_pkg
`default_nettype wire

// ===== rtl/frt_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fragment reassembly tracker core
// Single-pass update of the slot table for one fragment header and the
// result that the fragment produces.
// ----------------------------------------------------------------------------
module frt_core
	import frt_pkg::*;
(
	input  wire logic [15:0] part_key,
	input  wire logic [7:0]  len_code,
	input  wire slot_vec_t   slots,
	output slot_vec_t        slots_next,
	output result_t          result
);

	logic [SESSIONS-1:0] hit;
	logic [SESSIONS-1:0] sel;
	logic                seen;
	logic                found;
	slot_vec_t           mid;
	logic [7:0]          aged;
	logic [8:0]          sum;
	logic [SLOT_W-1:0]   alloc;
	logic [SLOT_W-1:0]   m_idx;
	logic [7:0]          m_parts;
	logic [2:0]          pos;
	logic [3:0]          full;
	logic                run;
	logic [11:0]         len;

	always_comb begin
		hit     = '0;
		sel     = '0;
		seen    = 1'b0;
		mid     = slots;
		alloc   = SLOT_W'(SESSIONS - 1);
		m_idx   = '0;
		m_parts = '0;
		aged    = '0;
		sum     = '0;
		pos     = len_code[2:0];
		full    = '0;
		run     = 1'b1;
		len     = '0;

		// Aging pass: every slot counts down, matching slots gain age, and
		// stale sessions are released.
		for (int i = 0; i < SESSIONS; i++) begin
			hit[i] = (slots[i].key == part_key);
			aged   = (slots[i].age != 8'd0) ? slots[i].age - 8'd1 : 8'd0;
			sum    = {1'b0, aged} + 9'(SESSIONS);
			if (hit[i]) begin
				mid[i].age = sum[8] ? AGE_MAX : sum[7:0];
				m_idx      = SLOT_W'(i);
			end else begin
				mid[i].age = aged;
				if (aged == 8'd0 && slots[i].key != 16'd0) begin
					mid[i].key   = '0;
					mid[i].parts = '0;
				end
			end
		end
		found = |hit;

		// The highest-numbered matching slot is the session.
		for (int i = SESSIONS - 1; i >= 0; i--) begin
			sel[i] = hit[i] && !seen;
			seen   = seen | hit[i];
		end
		for (int i = 0; i < SESSIONS; i++) begin
			if (sel[i])
				m_parts = m_parts | mid[i].parts;
			if (mid[i].key == 16'd0)
				alloc = SLOT_W'(i);
		end

		for (int k = 0; k < 8; k++) begin
			if (run && m_parts[k])
				full = full + 4'd1;
			else
				run = 1'b0;
		end

		slots_next            = mid;
		result.status         = ST_FRAME_ERR;
		result.deliver_length = '0;
		result.slot_used      = NO_SLOT;
		result.full_parts     = '0;

		if (len_code[7:3] == PART_MARK) begin
			if (pos == 3'd0) begin
				for (int i = 0; i < SESSIONS; i++) begin
					if (SLOT_W'(i) == alloc) begin
						slots_next[i].key   = part_key;
						slots_next[i].parts = 8'd1;
						slots_next[i].age   = START_AGE;
					end
				end
				result.status    = ST_STARTED;
				result.slot_used = 2'(alloc);
			end else if (!found) begin
				result.status = ST_LOST;
			end else if (!m_parts[3'(pos - 3'd1)]) begin
				// Predecessor missing: drop the session but keep its age.
				for (int i = 0; i < SESSIONS; i++) begin
					if (sel[i]) begin
						slots_next[i].key   = '0;
						slots_next[i].parts = '0;
					end
				end
				result.status    = ST_LOST;
				result.slot_used = 2'(m_idx);
			end else begin
				for (int i = 0; i < SESSIONS; i++) begin
					if (sel[i])
						slots_next[i].parts = mid[i].parts | (8'd1 << pos);
				end
				result.status    = ST_APPENDED;
				result.slot_used = 2'(m_idx);
			end
		end else if (len_code < 8'(PAYLOAD_BYTES)) begin
			result.status = ST_DELIVERED;
			if (!found) begin
				result.deliver_length = 11'(len_code);
			end else begin
				len = 12'(full) * 12'(PAYLOAD_BYTES) + 12'(len_code);
				result.deliver_length = len[11] ? LEN_MAX : len[10:0];
				result.slot_used      = 2'(m_idx);
				result.full_parts     = full;
			end
		end
	end

endmodule : frt_core
`default_nettype wire

// ===== rtl/fragment_reassembly_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Tracks sessions of fragmented frames by key and reports, for each
// fragment header, whether it started, extended, lost or delivered a frame, or is malformed.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     start / busy       part_key, len_code
//  result    done (strobe)      status, deliver_length, slot_used, full_parts
//
//  A transaction is taken on every cycle with start high; busy stays low.
//  Its result appears with done after the input register and the slot
//  table update into the result register. The slot table register is
//  loaded together with the result register, so back-to-back headers
//  see each other's effects. Reset empties every slot.
//  The receiver cannot stall; results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit
	import frt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] part_key,
	input  wire logic [7:0]  len_code,
	output logic             done,
	output logic [2:0]       status,
	output logic [10:0]      deliver_length,
	output logic [1:0]       slot_used,
	output logic [3:0]       full_parts
);

	logic        valid_s1;
	logic [15:0] key_s1;
	logic [7:0]  code_s1;
	slot_vec_t   slots_q;
	slot_vec_t   slots_next;
	result_t     result;
	logic        done_q;
	result_t     result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_s1  <= part_key;
			code_s1 <= len_code;
		end
	end

	frt_core u_core (
		.part_key   (key_s1),
		.len_code   (code_s1),
		.slots      (slots_q),
		.slots_next (slots_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1)
				slots_q <= slots_next;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			result_q <= result;
	end

	assign done           = done_q;
	assign status         = result_q.status;
	assign deliver_length = result_q.deliver_length;
	assign slot_used      = result_q.slot_used;
	assign full_parts     = result_q.full_parts;

endmodule : fragment_reassembly_tracker_unit
`default_nettype wire
